[sv/ycvt_pkg.sv]
package ycvt_pkg;

  localparam int unsigned CoefScale  = 1000000;
  localparam int unsigned CoefRedV   = 1370705;
  localparam int unsigned CoefBlueU  = 1732446;
  localparam int unsigned CoefGreenU = 337633;
  localparam int unsigned CoefGreenV = 698001;
  localparam int unsigned ChromaBias = 128;
  localparam int unsigned ChromaLevels = 256;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PixelW = 16;
  localparam int unsigned InDataW  = 4 * ByteW;
  localparam int unsigned OutDataW = 2 * PixelW;

  // signed chroma offset, largest magnitude is 221 (blue from u)
  typedef logic signed [8:0] off_t;
  typedef off_t off_tab_t [ChromaLevels];

  typedef struct packed {
    off_t off_r;
    off_t off_g;
    off_t off_b;
  } chroma_off_t;

  typedef struct packed {
    logic [ByteW-1:0] luma_first;
    logic [ByteW-1:0] chroma_blue;
    logic [ByteW-1:0] luma_second;
    logic [ByteW-1:0] chroma_red;
    logic             last;
  } macropix_t;

  // trunc(coef * (byte - 128) / 1e6) toward zero, built at elaboration
  function automatic off_tab_t build_off_tab(int unsigned coef);
    off_tab_t    tab;
    int          d;
    int unsigned mag;
    int unsigned q;
    for (int i = 0; i < int'(ChromaLevels); i++) begin
      d   = i - int'(ChromaBias);
      mag = (d < 0) ? int'(-d) : int'(d);
      q   = (mag * coef) / CoefScale;
      tab[i] = (d < 0) ? off_t'(-int'(q)) : off_t'(q);
    end
    return tab;
  endfunction

  localparam off_tab_t OffRedTab    = build_off_tab(CoefRedV);
  localparam off_tab_t OffBlueTab   = build_off_tab(CoefBlueU);
  localparam off_tab_t OffGreenUTab = build_off_tab(CoefGreenU);
  localparam off_tab_t OffGreenVTab = build_off_tab(CoefGreenV);

endpackage

[sv/ycvt_chroma.sv]
module ycvt_chroma (
  input  logic [ycvt_pkg::ByteW-1:0] chroma_blue_i,
  input  logic [ycvt_pkg::ByteW-1:0] chroma_red_i,
  output ycvt_pkg::chroma_off_t      offs_o
);
  import ycvt_pkg::*;

  off_t off_gu;
  off_t off_gv;

  assign off_gu = OffGreenUTab[chroma_blue_i];
  assign off_gv = OffGreenVTab[chroma_red_i];

  // green parts stay within +-133, no overflow in nine bits
  assign offs_o.off_r = OffRedTab[chroma_red_i];
  assign offs_o.off_b = OffBlueTab[chroma_blue_i];
  assign offs_o.off_g = off_gu + off_gv;

endmodule

[sv/ycvt_pixel.sv]
module ycvt_pixel (
  input  logic [ycvt_pkg::ByteW-1:0]  luma_i,
  input  ycvt_pkg::chroma_off_t       offs_i,
  output logic [ycvt_pkg::PixelW-1:0] pixel_o
);
  import ycvt_pkg::*;

  logic signed [10:0] luma_s;
  logic signed [10:0] sum_r;
  logic signed [10:0] sum_g;
  logic signed [10:0] sum_b;
  logic [ByteW-1:0]   red;
  logic [ByteW-1:0]   green;
  logic [ByteW-1:0]   blue;

  function automatic logic [ByteW-1:0] clamp8(logic signed [10:0] v);
    logic [ByteW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > 11'sd255) begin
      r = '1;
    end else begin
      r = v[ByteW-1:0];
    end
    return r;
  endfunction

  assign luma_s = $signed({3'b000, luma_i});
  assign sum_r  = luma_s + 11'(offs_i.off_r);
  assign sum_g  = luma_s - 11'(offs_i.off_g);
  assign sum_b  = luma_s + 11'(offs_i.off_b);

  assign red   = clamp8(sum_r);
  assign green = clamp8(sum_g);
  assign blue  = clamp8(sum_b);

  assign pixel_o = {red[7:3], green[7:2], blue[7:3]};

endmodule

[sv/yuyv_to_rgb565_converter.sv]
// Converts a stream of YUYV 4:2:2 macropixels to pairs of RGB565 pixels. Each input word
// carries Y0, U, Y1, V; each output word carries the two pixels, sharing the chroma of the
// word. Offsets follow the usual BT.601-style coefficients truncated toward zero, channels
// are clamped to 0..255 before packing, and tlast is carried along unchanged. The block
// takes one word every clock while the output is not stalled. An accepted word is held in
// the input register, where the chroma tables and the per-pixel add and clamp work on it,
// and its result is then registered in the output register. A stalled output holds its
// word; the input register still takes one more word and then tready drops until the output moves.
module yuyv_to_rgb565_converter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [7:0] luma_first, [15:8] chroma_blue, [23:16] luma_second, [31:24] chroma_red
  input  logic [ycvt_pkg::InDataW-1:0]       s_axis_tdata,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [15:0] pixel_first, [31:16] pixel_second
  output logic [ycvt_pkg::OutDataW-1:0]      m_axis_tdata,
  output logic                               m_axis_tlast
);
  import ycvt_pkg::*;

  logic        in_valid_q;
  logic        in_valid_d;
  macropix_t   in_word_q;
  logic        out_valid_q;
  logic        out_valid_d;
  logic [PixelW-1:0] pix0_q;
  logic [PixelW-1:0] pix1_q;
  logic              last_q;

  logic        advance;
  logic        s_accept;
  chroma_off_t offs;
  logic [PixelW-1:0] pix0;
  logic [PixelW-1:0] pix1;

  // output slot free or being emptied this cycle
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = s_axis_tready ? s_axis_tvalid : in_valid_q;
  assign out_valid_d = advance ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_word_q.luma_first  <= s_axis_tdata[7:0];
      in_word_q.chroma_blue <= s_axis_tdata[15:8];
      in_word_q.luma_second <= s_axis_tdata[23:16];
      in_word_q.chroma_red  <= s_axis_tdata[31:24];
      in_word_q.last        <= s_axis_tlast;
    end
  end

  ycvt_chroma u_chroma (
    .chroma_blue_i (in_word_q.chroma_blue),
    .chroma_red_i  (in_word_q.chroma_red),
    .offs_o        (offs)
  );

  ycvt_pixel u_pixel0 (
    .luma_i  (in_word_q.luma_first),
    .offs_i  (offs),
    .pixel_o (pix0)
  );

  ycvt_pixel u_pixel1 (
    .luma_i  (in_word_q.luma_second),
    .offs_i  (offs),
    .pixel_o (pix1)
  );

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      pix0_q <= pix0;
      pix1_q <= pix1;
      last_q <= in_word_q.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {pix1_q, pix0_q};
  assign m_axis_tlast  = last_q;

  // an accepted word always lands in the input register
  a_accept_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> in_valid_q)
    else $error("accepted word did not reach input register");

  // a loaded input register moves on when the output slot is free
  a_stage_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && advance) |=> out_valid_q)
    else $error("input word lost on its way to output register");

  // both registers full and output stalled: input must be held off
  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while pipeline full and stalled");

  // a stalled result keeps its pixels
  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(pix0_q) && $stable(pix1_q)))
    else $error("stalled result changed");

endmodule

[test/tb_yuyv_to_rgb565_converter.sv]
`timescale 1ns / 1ps

module tb_yuyv_to_rgb565_converter;

  localparam int unsigned CoefOne   = 1000000;
  localparam int unsigned RedFromV  = 1370705;
  localparam int unsigned BlueFromU = 1732446;
  localparam int unsigned GreenFromU = 337633;
  localparam int unsigned GreenFromV = 698001;
  localparam int          ChromaMid = 128;
  localparam int          ChannelTop = 255;

  localparam int RandomWords   = 200;   // per idling phase
  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 8;

  typedef struct packed {
    logic [15:0] pixel_first;
    logic [15:0] pixel_second;
    logic        last;
  } pixel_pair_t;

  class pixel_scoreboard;
    pixel_pair_t pending[$];
    int mismatches;
    int words_in;
    int words_out;
    int lasts_seen;

    // trunc(k * (c - 128) / 1e6) toward zero
    static function int chroma_term(int unsigned k, logic [7:0] c);
      int d;
      longint unsigned q;
      d = int'(c) - ChromaMid;
      q = longint'((d < 0) ? -d : d) * longint'(k) / longint'(CoefOne);
      return (d < 0) ? -int'(q) : int'(q);
    endfunction

    static function logic [7:0] clamp_channel(int v);
      if (v < 0) return 8'd0;
      if (v > ChannelTop) return 8'd255;
      return v[7:0];
    endfunction

    static function logic [15:0] rgb565_of(int y, int dr, int dg, int db);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      r = clamp_channel(y + dr);
      g = clamp_channel(y - dg);
      b = clamp_channel(y + db);
      return {r[7:3], g[7:2], b[7:3]};
    endfunction

    function void note_macropixel(logic [7:0] y0, logic [7:0] u, logic [7:0] y1,
                                  logic [7:0] v, logic last);
      int dr;
      int dg;
      int db;
      pixel_pair_t pp;
      dr = chroma_term(RedFromV, v);
      db = chroma_term(BlueFromU, u);
      dg = chroma_term(GreenFromU, u) + chroma_term(GreenFromV, v);
      pp.pixel_first  = rgb565_of(int'(y0), dr, dg, db);
      pp.pixel_second = rgb565_of(int'(y1), dr, dg, db);
      pp.last         = last;
      pending.push_back(pp);
      words_in++;
      if (last) lasts_seen++;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_pixels(logic [31:0] data, logic last);
      pixel_pair_t want;
      words_out++;
      if (pending.size() == 0) begin
        report($sformatf("word %h last %b with nothing expected", data, last));
      end else begin
        want = pending.pop_front();
        if (data[15:0] !== want.pixel_first)
          report($sformatf("word %0d pixel_first %h, want %h", words_out,
                           data[15:0], want.pixel_first));
        if (data[31:16] !== want.pixel_second)
          report($sformatf("word %0d pixel_second %h, want %h", words_out,
                           data[31:16], want.pixel_second));
        if (last !== want.last)
          report($sformatf("word %0d last %b, want %b", words_out, last, want.last));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  pixel_scoreboard pixels = new();
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int quiet_cycles  = 0;

  always #6 clk_i = ~clk_i;

  yuyv_to_rgb565_converter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // called in the step of a rising edge, returns in the step of the accepting edge
  task automatic send_macropixel(logic [7:0] y0, logic [7:0] u, logic [7:0] y1,
                                 logic [7:0] v, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, y1, u, y0};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pixels.note_macropixel(y0, u, y1, v, last);
  endtask

  // mostly uniform, sometimes right at the edges where clamping kicks in
  function automatic logic [7:0] pick_byte();
    logic [7:0] edges [9] = '{8'd0, 8'd1, 8'd2, 8'd127, 8'd128, 8'd129,
                              8'd253, 8'd254, 8'd255};
    if ($urandom_range(99) < 30) return edges[$urandom_range(8)];
    return 8'($urandom);
  endfunction

  // sink side: check accepted words, then pick next tready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      pixels.check_pixels(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (quiet_cycles == WatchdogLimit) begin
      $display("[%0t] timeout: no word moved for %0d cycles", $time, WatchdogLimit);
      $display("end of test: mismatches");
      $finish;
    end else if (!rst_ni || (s_axis_tvalid && s_axis_tready) ||
                 (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [7:0] levels [3] = '{8'd0, 8'd128, 8'd255};
    int src_pcts [4]  = '{0, 46, 0, 12};
    int sink_pcts [4] = '{0, 0, 46, 12};
    int n;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // chroma at both ends and neutral, luma at both ends
    n = 0;
    for (int yi = 0; yi < 2; yi++) begin
      for (int ui = 0; ui < 3; ui++) begin
        for (int vi = 0; vi < 3; vi++) begin
          send_macropixel(yi ? 8'd255 : 8'd0, levels[ui], yi ? 8'd0 : 8'd255,
                          levels[vi], (n % 5) == 4);
          n++;
        end
      end
    end
    send_macropixel(8'd16, 8'd127, 8'd235, 8'd129, 1'b0);
    send_macropixel(8'd128, 8'd1, 8'd200, 8'd254, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = src_pcts[ph];
      sink_stall_pct = sink_pcts[ph];
      for (int i = 0; i < RandomWords; i++)
        send_macropixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                        $urandom_range(7) == 0);
    end
    s_axis_tvalid <= 1'b0;

    while (pixels.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("converted %0d macropixels (%0d marked last), %0d pixel pairs compared",
             pixels.words_in, pixels.lasts_seen, pixels.words_out);
    $display("idling covered: none, sender only, receiver only, both together");
    if (pixels.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
sv/ycvt_pkg.sv
sv/ycvt_chroma.sv
sv/ycvt_pixel.sv
sv/yuyv_to_rgb565_converter.sv
test/tb_yuyv_to_rgb565_converter.sv
